FILE: rtl/lcg_pkg.sv
// ----------------------------------------------------------------------------
// lcg_pkg: shared types, constants and table builder for the chirp generator
// Holds register index codes, reset values, the output queue sizing and the
// constant function that computes one quarter-wave cosine table entry.
// ----------------------------------------------------------------------------
package lcg_pkg;

    // configuration port
    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 32;
    localparam int SWEEP_BITS     = 16;

    localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_OFFSET = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_STEP   = 8'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_DELTA   = 8'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SWEEP_LENGTH = 8'd3;

    localparam logic [SWEEP_BITS-1:0] SWEEP_LENGTH_RESET = 16'd5000;

    // output queue: deep enough to cover the two pipeline stages plus one
    localparam int OUT_DEPTH    = 4;
    localparam int OUT_PTR_BITS = 2;
    localparam int OUT_CNT_BITS = 3;

    // fixed-point constants for the table builder (Q2.30)
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    // per-sample side info carried down the pipeline
    typedef struct packed {
        logic neg;
        logic last;
    } t_tag;

    // cosine at the midpoint of quarter-wave cell k, scaled to smp_max
    // Taylor series in even powers up to x^18, truncating at each term
    function automatic logic [63:0] cell_cos(input int k, input int addr_bits,
                                             input logic [63:0] smp_max);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        x    = (HALF_PI_Q30 * 64'(2 * k + 1)) >> (addr_bits + 1);
        x2   = (x * x) >> 30;
        term = ONE_Q30;
        sum  = longint'(ONE_Q30);
        term = ((term * x2) >> 30) / 64'd2;   sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd12;  sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd30;  sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd56;  sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd90;  sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd132; sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd182; sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd240; sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd306; sum = sum - longint'(term);
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > longint'(ONE_Q30)) begin
            sum = longint'(ONE_Q30);
        end
        return (64'($unsigned(sum)) * smp_max + (ONE_Q30 >> 1)) >> 30;
    endfunction

endpackage

FILE: rtl/lcg_phase.sv
// ----------------------------------------------------------------------------
// lcg_phase: phase and step accumulators with sweep control
// Picks the phase of the accepted sample, advances both accumulators and the
// sample counter, and registers the folded table address and sign.
// ----------------------------------------------------------------------------
module lcg_phase
    import lcg_pkg::*;
#(
    parameter int PHASE_BITS      = 32,
    parameter int TABLE_ADDR_BITS = 10
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_acc,
    input  logic                       i_restart,
    input  logic [CFG_DATA_BITS-1:0]   i_phase_offset,
    input  logic [CFG_DATA_BITS-1:0]   i_first_step,
    input  logic [CFG_DATA_BITS-1:0]   i_step_delta,
    input  logic [SWEEP_BITS-1:0]      i_sweep_length,
    output logic                       o_valid,
    output logic [TABLE_ADDR_BITS-1:0] o_addr,
    output t_tag                       o_tag
);

    localparam int IDX_BITS = TABLE_ADDR_BITS + 2;

    logic [PHASE_BITS-1:0]      w_offset_al;
    logic [PHASE_BITS-1:0]      w_first_al;
    logic [PHASE_BITS-1:0]      w_delta_al;
    logic                       w_start;
    logic [PHASE_BITS-1:0]      w_ph;
    logic [PHASE_BITS-1:0]      w_st;
    logic [SWEEP_BITS-1:0]      w_cnt;
    logic [SWEEP_BITS:0]        w_cnt_inc;
    logic                       w_last;
    logic [IDX_BITS-1:0]        w_idx;
    logic [1:0]                 w_quad;
    logic [TABLE_ADDR_BITS-1:0] w_cell;

    logic [PHASE_BITS-1:0]      r_phase;
    logic [PHASE_BITS-1:0]      r_step;
    logic [SWEEP_BITS-1:0]      r_count;
    logic                       r_valid;
    logic [TABLE_ADDR_BITS-1:0] r_addr;
    t_tag                       r_tag;

    // align 32-bit registers to the top of the phase word
    if (PHASE_BITS >= CFG_DATA_BITS) begin : g_align_up
        assign w_offset_al = PHASE_BITS'(i_phase_offset) << (PHASE_BITS - CFG_DATA_BITS);
        assign w_first_al  = PHASE_BITS'(i_first_step) << (PHASE_BITS - CFG_DATA_BITS);
        assign w_delta_al  = PHASE_BITS'(i_step_delta) << (PHASE_BITS - CFG_DATA_BITS);
    end else begin : g_align_down
        assign w_offset_al = i_phase_offset[CFG_DATA_BITS-1 -: PHASE_BITS];
        assign w_first_al  = i_first_step[CFG_DATA_BITS-1 -: PHASE_BITS];
        assign w_delta_al  = i_step_delta[CFG_DATA_BITS-1 -: PHASE_BITS];
    end

    // sweep start: restart request or counter back at zero
    assign w_start   = i_restart | (r_count == '0);
    assign w_ph      = w_start ? w_offset_al : r_phase;
    assign w_st      = w_start ? w_first_al : r_step;
    assign w_cnt     = w_start ? '0 : r_count;
    assign w_cnt_inc = {1'b0, w_cnt} + (SWEEP_BITS + 1)'(1);
    assign w_last    = w_cnt_inc >= {1'b0, i_sweep_length};

    // quadrant fold: odd quadrants read the table mirrored
    assign w_idx  = w_ph[PHASE_BITS-1 -: IDX_BITS];
    assign w_quad = w_idx[IDX_BITS-1 -: 2];
    assign w_cell = w_quad[0] ? ~w_idx[TABLE_ADDR_BITS-1:0] : w_idx[TABLE_ADDR_BITS-1:0];

    // accumulator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_step  <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_in_acc;
            if (i_in_acc) begin
                r_phase <= w_ph + w_st;
                r_step  <= w_st + w_delta_al;
                r_count <= w_last ? '0 : w_cnt_inc[SWEEP_BITS-1:0];
            end
        end
    end

    // table address and sign for the next stage
    always_ff @(posedge i_clk) begin
        if (i_in_acc) begin
            r_addr     <= w_cell;
            r_tag.neg  <= w_quad[0] ^ w_quad[1];
            r_tag.last <= w_last;
        end
    end

    assign o_valid = r_valid;
    assign o_addr  = r_addr;
    assign o_tag   = r_tag;

endmodule

FILE: rtl/lcg_rom.sv
// ----------------------------------------------------------------------------
// lcg_rom: quarter-wave cosine table with registered read
// Entries are built at elaboration from the package table function; the read
// data and the side info are registered together.
// ----------------------------------------------------------------------------
module lcg_rom
    import lcg_pkg::*;
#(
    parameter int SAMPLE_BITS     = 16,
    parameter int TABLE_ADDR_BITS = 10
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [TABLE_ADDR_BITS-1:0] i_addr,
    input  t_tag                       i_tag,
    output logic                       o_valid,
    output logic [SAMPLE_BITS-2:0]     o_mag,
    output t_tag                       o_tag
);

    localparam int          TBL_SIZE = 1 << TABLE_ADDR_BITS;
    localparam logic [63:0] SMP_MAX  = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

    logic [SAMPLE_BITS-2:0] w_rom [TBL_SIZE];

    logic                   r_valid;
    logic [SAMPLE_BITS-2:0] r_mag;
    t_tag                   r_tag;

    // constant table contents
    for (genvar k = 0; k < TBL_SIZE; k++) begin : g_tbl
        localparam logic [63:0] ENTRY = cell_cos(k, TABLE_ADDR_BITS, SMP_MAX);
        assign w_rom[k] = ENTRY[SAMPLE_BITS-2:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_mag <= w_rom[i_addr];
            r_tag <= i_tag;
        end
    end

    assign o_valid = r_valid;
    assign o_mag   = r_mag;
    assign o_tag   = r_tag;

endmodule

FILE: rtl/lcg_out_fifo.sv
// ----------------------------------------------------------------------------
// lcg_out_fifo: small output queue
// Holds finished samples while the consumer stalls, so the pipeline in front
// never has to stop mid-flight.
// ----------------------------------------------------------------------------
module lcg_out_fifo
    import lcg_pkg::*;
#(
    parameter int WIDTH = 17
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_wr,
    input  logic [WIDTH-1:0]        i_data,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [WIDTH-1:0]        o_data,
    output logic [OUT_CNT_BITS-1:0] o_count
);

    logic [WIDTH-1:0]        r_mem [OUT_DEPTH];
    logic [OUT_PTR_BITS-1:0] r_wr_ptr;
    logic [OUT_PTR_BITS-1:0] r_rd_ptr;
    logic [OUT_CNT_BITS-1:0] r_count;
    logic                    w_rd;

    assign w_rd = (r_count != '0) & i_ready;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + OUT_PTR_BITS'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + OUT_PTR_BITS'(1);
            end
            case ({i_wr, w_rd})
                2'b10:   r_count <= r_count + OUT_CNT_BITS'(1);
                2'b01:   r_count <= r_count - OUT_CNT_BITS'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

FILE: rtl/linear_chirp_generator.sv
// ----------------------------------------------------------------------------
// linear_chirp_generator: linear-FM chirp sample source
// Each accepted tick transaction yields one cosine sample of a quadratic
// phase, built from a phase accumulator and a step accumulator.
// ----------------------------------------------------------------------------
// One sample per clock while the consumer keeps up: a tick transaction is
// taken every cycle and its sample passes the accumulators and the registered
// cosine table read, and is signed into the queue. The four-entry output
// queue absorbs consumer stalls; the input is ready while queue fill plus
// in-flight samples is below four. Phase offset and first step writes take
// effect at the next sweep start (sample zero or a restart tick); step delta
// and length writes apply from the next tick. A zero length acts as one.
// ----------------------------------------------------------------------------
module linear_chirp_generator
    import lcg_pkg::*;
#(
    parameter int PHASE_BITS      = 32,
    parameter int SAMPLE_BITS     = 16,
    parameter int TABLE_ADDR_BITS = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]     i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      i_cfg_data,
    // tick input channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_restart,
    // sample output channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [SAMPLE_BITS-1:0] o_sample,
    output logic                          o_sweep_end
);

    localparam int OUT_WIDTH = SAMPLE_BITS + 1;

    logic [CFG_DATA_BITS-1:0]   r_phase_offset;
    logic [CFG_DATA_BITS-1:0]   r_first_step;
    logic [CFG_DATA_BITS-1:0]   r_step_delta;
    logic [SWEEP_BITS-1:0]      r_sweep_length;

    logic                       w_cfg_wr;
    logic                       w_in_acc;
    logic                       w_ph_valid;
    logic [TABLE_ADDR_BITS-1:0] w_ph_addr;
    t_tag                       w_ph_tag;
    logic                       w_rom_valid;
    logic [SAMPLE_BITS-2:0]     w_rom_mag;
    t_tag                       w_rom_tag;
    logic [SAMPLE_BITS-1:0]     w_mag_ext;
    logic [SAMPLE_BITS-1:0]     w_sample;
    logic [OUT_WIDTH-1:0]       w_fifo_out;
    logic [OUT_CNT_BITS-1:0]    w_fifo_count;
    logic [OUT_CNT_BITS-1:0]    w_load;

    // configuration registers
    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid & o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_offset <= '0;
            r_first_step   <= '0;
            r_step_delta   <= '0;
            r_sweep_length <= SWEEP_LENGTH_RESET;
        end else if (w_cfg_wr) begin
            case (i_cfg_index)
                REG_PHASE_OFFSET: r_phase_offset <= i_cfg_data;
                REG_FIRST_STEP:   r_first_step   <= i_cfg_data;
                REG_STEP_DELTA:   r_step_delta   <= i_cfg_data;
                REG_SWEEP_LENGTH: r_sweep_length <= i_cfg_data[SWEEP_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // input flow control: queue fill plus samples still in the pipeline
    assign w_load = w_fifo_count + OUT_CNT_BITS'(w_ph_valid) + OUT_CNT_BITS'(w_rom_valid);
    assign o_in_ready = w_load < OUT_CNT_BITS'(OUT_DEPTH);
    assign w_in_acc   = i_in_valid & o_in_ready;

    lcg_phase #(
        .PHASE_BITS      (PHASE_BITS),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_phase (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_acc       (w_in_acc),
        .i_restart      (i_restart),
        .i_phase_offset (r_phase_offset),
        .i_first_step   (r_first_step),
        .i_step_delta   (r_step_delta),
        .i_sweep_length (r_sweep_length),
        .o_valid        (w_ph_valid),
        .o_addr         (w_ph_addr),
        .o_tag          (w_ph_tag)
    );

    lcg_rom #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
    ) u_rom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_ph_valid),
        .i_addr  (w_ph_addr),
        .i_tag   (w_ph_tag),
        .o_valid (w_rom_valid),
        .o_mag   (w_rom_mag),
        .o_tag   (w_rom_tag)
    );

    // apply the quadrant sign
    assign w_mag_ext = {1'b0, w_rom_mag};
    assign w_sample  = w_rom_tag.neg ? (~w_mag_ext + SAMPLE_BITS'(1)) : w_mag_ext;

    lcg_out_fifo #(
        .WIDTH (OUT_WIDTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_rom_valid),
        .i_data  ({w_rom_tag.last, w_sample}),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (w_fifo_out),
        .o_count (w_fifo_count)
    );

    assign o_sample    = w_fifo_out[SAMPLE_BITS-1:0];
    assign o_sweep_end = w_fifo_out[SAMPLE_BITS];

    // checks
    a_no_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rom_valid |-> (w_fifo_count != OUT_CNT_BITS'(OUT_DEPTH) || i_out_ready))
        else $error("output queue written while full");

    a_load_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load <= OUT_CNT_BITS'(OUT_DEPTH))
        else $error("samples in flight exceed queue room");

    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |-> ##2 w_rom_valid)
        else $error("accepted tick did not reach the queue two cycles later");

    a_no_min_sample : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_sample != {1'b1, {(SAMPLE_BITS - 1){1'b0}}}))
        else $error("sample reached the most negative code");

endmodule

FILE: bench/chirp_sample_checker.sv
// ----------------------------------------------------------------------------
// chirp_sample_checker: prediction and comparison for the chirp generator
// Watches the register, tick and sample channels. Every accepted tick is
// run through a local phase/step accumulator model and a locally built
// quarter-wave cosine table. Every accepted sample is then compared, field by
// field, against the oldest prediction.
// ----------------------------------------------------------------------------
module chirp_sample_checker
    import lcg_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // register write channel
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    // tick channel
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  logic                      i_restart,
    // sample channel
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic signed [15:0]        i_sample,
    input  logic                      i_sweep_end,
    // status toward the top
    output int                        o_fail_count,
    output int                        o_pending
);

    // phase is 32 bits, so the 32-bit registers need no alignment shift
    localparam int PHASE_W  = 32;
    localparam int SAMPLE_W = 16;
    localparam int ADDR_W   = 10;
    localparam int TBL_N    = 1 << ADDR_W;

    localparam logic [63:0] HALF_PI_FX = 64'd1686629713;  // pi/2 in Q2.30
    localparam logic [63:0] UNIT_FX    = 64'd1 << 30;
    localparam logic [63:0] PEAK       = (64'd1 << (SAMPLE_W - 1)) - 64'd1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] amplitude;
        logic                       sweep_end;
    } chirp_out_t;

    logic [SAMPLE_W-1:0] quarter_tbl [TBL_N];

    // register copies
    logic [PHASE_W-1:0]    start_phase;
    logic [PHASE_W-1:0]    start_step;
    logic [PHASE_W-1:0]    step_growth;
    logic [SWEEP_BITS-1:0] sweep_len;

    // accumulator state
    logic [PHASE_W-1:0]    phase_acc;
    logic [PHASE_W-1:0]    step_acc;
    logic [SWEEP_BITS-1:0] sweep_pos;

    chirp_out_t expected_q[$];
    int         n_fail = 0;

    // cosine at the middle of quarter-wave cell k: even Taylor terms up to
    // x^18, each truncated, then scaled to the sample peak with rounding
    function automatic logic [SAMPLE_W-1:0] quarter_cos_entry(input int k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      acc;
        int          n;
        x    = (HALF_PI_FX * 64'(2 * k + 1)) >> (ADDR_W + 1);
        x2   = (x * x) >> 30;
        term = UNIT_FX;
        acc  = longint'(UNIT_FX);
        for (n = 1; n <= 9; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
            if (n % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        if (acc > longint'(UNIT_FX)) begin
            acc = longint'(UNIT_FX);
        end
        return SAMPLE_W'((64'(acc) * PEAK + (UNIT_FX >> 1)) >> 30);
    endfunction

    initial begin : build_table
        int k;
        for (k = 0; k < TBL_N; k++) begin
            quarter_tbl[k] = quarter_cos_entry(k);
        end
    end

    // quadrant from the top two phase bits, table address from the next ones
    function automatic logic signed [SAMPLE_W-1:0] cosine_of(input logic [PHASE_W-1:0] ph);
        logic [1:0]          quad;
        logic [ADDR_W-1:0]   addr;
        logic [ADDR_W-1:0]   mirror;
        logic [SAMPLE_W-1:0] mag;
        quad   = ph[PHASE_W-1 -: 2];
        addr   = ph[PHASE_W-3 -: ADDR_W];
        mirror = ~addr;
        mag    = quad[0] ? quarter_tbl[mirror] : quarter_tbl[addr];
        return (quad[1] ^ quad[0]) ? -mag : mag;
    endfunction

    task automatic apply_write(input logic [CFG_INDEX_BITS-1:0] idx,
                               input logic [CFG_DATA_BITS-1:0] val);
        case (idx)
            REG_PHASE_OFFSET: start_phase = val;
            REG_FIRST_STEP:   start_step  = val;
            REG_STEP_DELTA:   step_growth = val;
            REG_SWEEP_LENGTH: sweep_len   = val[SWEEP_BITS-1:0];
            default: ;  // unmapped index, dropped
        endcase
    endtask

    // one tick: offset and first step are picked up only at a sweep start
    task automatic predict_sample(input logic rs);
        logic [PHASE_W-1:0] ph;
        logic [PHASE_W-1:0] st;
        logic               ends;
        chirp_out_t         want;
        if (rs || sweep_pos == '0) begin
            sweep_pos = '0;
            ph        = start_phase;
            st        = start_step;
        end else begin
            ph = phase_acc;
            st = step_acc;
        end
        // a zero length behaves like one; a lowered length ends at once
        ends           = ({1'b0, sweep_pos} + 17'd1) >= {1'b0, sweep_len};
        want.amplitude = cosine_of(ph);
        want.sweep_end = ends;
        expected_q.push_back(want);
        phase_acc = ph + st;
        step_acc  = st + step_growth;
        sweep_pos = ends ? '0 : sweep_pos + 1'b1;
    endtask

    task automatic check_result(input logic signed [SAMPLE_W-1:0] got_amp,
                                input logic got_end);
        chirp_out_t want;
        if (expected_q.size() == 0) begin
            $error("sample: no transaction pending, actual %0d", got_amp);
            n_fail++;
        end else begin
            want = expected_q.pop_front();
            if (got_amp !== want.amplitude) begin
                $error("sample: expected %0d, actual %0d",
                       $signed(want.amplitude), got_amp);
                n_fail++;
            end
            if (got_end !== want.sweep_end) begin
                $error("sweep_end: expected %0b, actual %0b", want.sweep_end, got_end);
                n_fail++;
            end
        end
    endtask

    // results are checked before new ticks, so a same-edge result can never
    // match a tick taken at that very edge; a register write lands after the
    // edge, so a tick taken at the same edge still sees the old value
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start_phase = '0;
            start_step  = '0;
            step_growth = '0;
            sweep_len   = SWEEP_LENGTH_RESET;
            phase_acc   = '0;
            step_acc    = '0;
            sweep_pos   = '0;
            expected_q.delete();
            o_pending <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                check_result(i_sample, i_sweep_end);
            end
            if (i_in_valid && i_in_ready) begin
                predict_sample(i_restart);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                apply_write(i_cfg_index, i_cfg_data);
            end
            o_pending <= expected_q.size();
        end
        o_fail_count <= n_fail;
    end

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: top level for the linear chirp generator
// Programs the sweep registers between phases, drives tick transactions with
// random gaps and a random consumer stall pattern, and reports the verdict
// from the sample checker. A short directed part covers the register
// extremes, zero and one sample sweeps, restart mid-sweep and a length cut
// mid-sweep; random phases follow.
// ----------------------------------------------------------------------------
module testbench
    import lcg_pkg::*;
();

    localparam int SETTLE      = 8;     // cycles after the last sample
    localparam int HOLD_CYCLES = 300;   // long consumer hold-off
    localparam int STALL_LIMIT = 2000;  // cycles with no transaction at all

    logic clk = 1'b0;
    logic rst_n;

    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic                      in_valid;
    logic                      in_ready;
    logic                      restart;
    logic                      out_valid;
    logic                      out_ready;
    logic signed [15:0]        sample;
    logic                      sweep_end;

    int fail_count;
    int pending;
    int idle_cycles = 0;
    bit hold_sink   = 1'b0;

    always #10 clk = ~clk;

    linear_chirp_generator dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_restart   (restart),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_sample    (sample),
        .o_sweep_end (sweep_end)
    );

    chirp_sample_checker sample_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_restart    (restart),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_sample     (sample),
        .i_sweep_end  (sweep_end),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // mostly back to back, sometimes a few cycles, rarely a long gap
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] corner_word();
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // short sweeps dominate so sweep ends are frequent; upper bits are junk
    function automatic logic [31:0] length_word();
        logic [15:0] len;
        case ($urandom_range(0, 9))
            0, 1, 2: len = 16'($urandom_range(0, 3));
            8:       len = 16'hFFFF;
            9:       len = 16'($urandom);
            default: len = 16'($urandom_range(4, 60));
        endcase
        return {16'($urandom), len};
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // valid stays high across back-to-back ticks
    task automatic send_tick(input logic rs, input int gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        restart  <= rs;
        do @(posedge clk); while (!in_ready);
    endtask

    // stop offering ticks and wait until every sample has come back
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic program_sweep(input logic [31:0] po, input logic [31:0] fs,
                                 input logic [31:0] sd, input logic [31:0] len);
        write_reg(REG_PHASE_OFFSET, po);
        write_reg(REG_FIRST_STEP, fs);
        write_reg(REG_STEP_DELTA, sd);
        write_reg(REG_SWEEP_LENGTH, len);
    endtask

    // random registers, some left as they were so settings carry over
    task automatic random_setup();
        if ($urandom_range(0, 3) != 0) write_reg(REG_PHASE_OFFSET, corner_word());
        if ($urandom_range(0, 3) != 0) write_reg(REG_FIRST_STEP, corner_word());
        if ($urandom_range(0, 3) != 0) write_reg(REG_STEP_DELTA, corner_word());
        if ($urandom_range(0, 3) != 0) write_reg(REG_SWEEP_LENGTH, length_word());
        if ($urandom_range(0, 3) == 0) begin
            write_reg(CFG_INDEX_BITS'($urandom_range(4, 255)), $urandom);
        end
    endtask

    // each burst is randomly dense or gapped; the pressure phase asks the
    // consumer to hold off and keeps pushing ticks back to back
    task automatic random_phase(input int n_items, input bit with_hold);
        int  k;
        int  burst;
        bit  dense;
        burst = 0;
        dense = 1'b0;
        for (k = 0; k < n_items; k++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 30);
                dense = ($urandom_range(0, 2) == 0);
            end
            burst--;
            if (with_hold && k == 4) begin
                hold_sink = 1'b1;
            end
            send_tick($urandom_range(0, 19) == 0, (with_hold || dense) ? 0 : idle_gap());
        end
        drain();
    endtask

    // consumer: random ready pattern, with the long hold-off on request
    initial begin : sink
        int run;
        int c;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if (hold_sink) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_sink = 1'b0;
            end
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    out_ready <= 1'b0;
                    run = $urandom_range(1, 3);
                end
                3: begin
                    out_ready <= 1'b0;
                    run = $urandom_range(15, 50);
                end
                default: begin
                    out_ready <= 1'b1;
                    run = $urandom_range(1, 40);
                end
            endcase
            c = 0;
            do begin
                @(posedge clk);
                c++;
            end while (c < run && !hold_sink);
        end
    end

    // watchdog: any accepted transaction restarts the count
    always @(posedge clk) begin
        if (!rst_n || (cfg_valid && cfg_ready) || (in_valid && in_ready) ||
            (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus and verdict
    initial begin : stimulus
        int p;
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        restart   <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers: flat phase zero
        send_tick(1'b0, 0);
        send_tick(1'b0, 0);
        send_tick(1'b0, 2);
        drain();

        // one-sample sweeps with the widest step values
        program_sweep(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1);
        send_tick(1'b0, 0);
        send_tick(1'b1, 0);
        send_tick(1'b0, 1);
        send_tick(1'b0, 0);
        drain();

        // zero length acts as one; junk in the upper data bits
        program_sweep(32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_0000);
        send_tick(1'b0, 0);
        send_tick(1'b0, 0);
        send_tick(1'b1, 0);
        drain();

        // quadrant boundary start, restart in the middle of a sweep
        program_sweep(32'h4000_0000, 32'h0010_0000, 32'h0000_1000, 32'd6);
        send_tick(1'b0, 0);
        send_tick(1'b0, 0);
        send_tick(1'b0, 0);
        send_tick(1'b1, 0);
        send_tick(1'b0, 0);
        send_tick(1'b0, 3);
        send_tick(1'b0, 0);
        drain();

        // length cut below the current position ends the sweep at once;
        // the new start phase waits for the next sweep start
        write_reg(REG_SWEEP_LENGTH, 32'd20);
        send_tick(1'b1, 0);
        send_tick(1'b0, 0);
        send_tick(1'b0, 0);
        send_tick(1'b0, 0);
        send_tick(1'b0, 0);
        drain();
        write_reg(REG_SWEEP_LENGTH, 32'd2);
        write_reg(REG_PHASE_OFFSET, 32'hC000_0000);
        write_reg(CFG_INDEX_BITS'(4), 32'hDEAD_BEEF);
        write_reg({CFG_INDEX_BITS{1'b1}}, 32'h5555_AAAA);
        send_tick(1'b0, 0);
        send_tick(1'b0, 0);
        send_tick(1'b0, 0);
        drain();

        // random phases, one of them under a long consumer hold-off
        for (p = 0; p < 10; p++) begin
            random_setup();
            random_phase($urandom_range(40, 60), p == 3);
        end

        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
